// ===== rtl/vlcp_pkg.sv =====
package vlcp_pkg;

    localparam int WORD_BYTES = 4;
    localparam int WORD_BITS  = 8 * WORD_BYTES;
    localparam int LEN_W      = 6;
    localparam int SYM_W      = 8;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_ENC  = 2'd1,
        MODE_END  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [WORD_BITS-1:0] code;
        logic [LEN_W-1:0]     len;
    } t_entry;

endpackage

// ===== rtl/variable_length_code_packer_unit.sv =====
// channel  | dir | tdata (low bit up)                          | side bits
// ---------+-----+---------------------------------------------+---------------
// s_axis   | in  | symbol[7:0] code_value[39:8] code_length[45:40] | tuser = mode
// m_axis   | out | packed_word[31:0] total_bits[63:32]           | tlast = is_last
//
// One beat per cycle is sustained while the sink keeps accepting output words.
// Beat 1 reads the code table (synchronous memory, one read port, one write port);
// beat 2 merges the code into the word register and loads the output register.
// Table loads write at acceptance, so a following encode sees the new entry.
// Reset clears control state and the per-entry valid bits at once; no clearing pass.
// Input stalls only when the output register is full, the merge stage holds a beat
// and the sink holds tready low.
module variable_length_code_packer_unit
    import vlcp_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // symbol, code_value, code_length, 2'b0
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,  // mode
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // packed_word, total_bits
    output logic                 o_m_axis_tlast
);

    localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    t_entry r_mem [SYMBOL_COUNT];
    logic   r_vld [SYMBOL_COUNT];

    logic [SYM_W-1:0]     in_sym;
    logic [WORD_BITS-1:0] in_code;
    logic [LEN_W-1:0]     in_len;
    logic [LEN_W-1:0]     ld_len;
    logic [WORD_BITS-1:0] ld_mask;
    logic                 in_range;
    logic [AW-1:0]        in_addr;
    logic                 accept;
    logic                 s1_go;

    logic                 r_s1_valid;
    t_mode                r_s1_mode;
    logic                 r_s1_range;
    t_entry               r_rd_data;
    logic                 r_rd_vld;

    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [LEN_W-1:0]     r_free, n_free;
    logic [WORD_BITS-1:0] r_total, n_total;
    logic                 r_sent, n_sent;

    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_word, n_out_word;
    logic [WORD_BITS-1:0] r_out_total;
    logic                 r_out_last, n_out_last;
    logic                 emit;

    logic [WORD_BITS-1:0] e_code;
    logic [LEN_W-1:0]     e_len;
    logic [LEN_W-1:0]     nf;
    logic [LEN_W-1:0]     spill;
    logic [LEN_W-1:0]     rem;

    assign in_sym   = i_s_axis_tdata[SYM_W-1:0];
    assign in_code  = i_s_axis_tdata[SYM_W +: WORD_BITS];
    assign in_len   = i_s_axis_tdata[SYM_W+WORD_BITS +: LEN_W];
    assign in_range = ({1'b0, in_sym} < (SYM_W+1)'(SYMBOL_COUNT));
    assign in_addr  = in_sym[AW-1:0];

    assign ld_len  = (in_len > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS) : in_len;
    assign ld_mask = (ld_len == LEN_W'(WORD_BITS)) ? '1
                   : ((WORD_BITS'(1) << ld_len) - WORD_BITS'(1));

    assign s1_go           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_go;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // table: write on in-range load beats, registered read on every accepted beat
    always_ff @(posedge i_clk) begin
        if (accept && in_range && t_mode'(i_s_axis_tuser) == MODE_LOAD) begin
            r_mem[in_addr] <= '{code: in_code & ld_mask, len: ld_len};
        end
        if (accept) begin
            r_rd_data <= r_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SYMBOL_COUNT; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else if (accept) begin
            if (in_range && t_mode'(i_s_axis_tuser) == MODE_LOAD) begin
                r_vld[in_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[in_addr];
        end
    end

    // merge stage
    assign e_code = (r_rd_vld && r_s1_range) ? r_rd_data.code : '0;
    assign e_len  = (r_rd_vld && r_s1_range) ? r_rd_data.len : '0;
    assign nf     = r_free - e_len;
    assign spill  = e_len - r_free;
    assign rem    = LEN_W'(WORD_BITS) - spill;

    always_comb begin
        n_acc      = r_acc;
        n_free     = r_free;
        n_total    = r_total;
        n_sent     = r_sent;
        n_out_word = r_acc;
        n_out_last = 1'b0;
        emit       = 1'b0;
        case (r_s1_mode)
            MODE_ENC: begin
                n_total = r_total + WORD_BITS'(e_len);
                if (e_len == '0) begin
                    emit = 1'b0;
                end else if (e_len <= r_free) begin
                    n_acc  = r_acc | (e_code << nf);
                    n_free = nf;
                    if (nf == '0) begin
                        emit       = 1'b1;
                        n_out_word = r_acc | e_code;
                        n_acc      = '0;
                        n_free     = LEN_W'(WORD_BITS);
                        n_sent     = 1'b1;
                    end
                end else begin
                    emit       = 1'b1;
                    n_out_word = r_acc | (e_code >> spill);
                    n_free     = rem;
                    n_acc      = e_code << rem;
                    n_sent     = 1'b1;
                end
            end
            MODE_END: begin
                n_out_last = 1'b1;
                if (r_free < LEN_W'(WORD_BITS)) begin
                    emit = 1'b1;
                end else if (!r_sent) begin
                    emit       = 1'b1;
                    n_out_word = '0;
                end
                n_acc   = '0;
                n_free  = LEN_W'(WORD_BITS);
                n_total = '0;
                n_sent  = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_acc       <= '0;
            r_free      <= LEN_W'(WORD_BITS);
            r_total     <= '0;
            r_sent      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_s1_valid <= accept;
            end
            if (r_s1_valid && s1_go) begin
                r_acc   <= n_acc;
                r_free  <= n_free;
                r_total <= n_total;
                r_sent  <= n_sent;
            end
            if (s1_go) begin
                r_out_valid <= r_s1_valid && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode  <= t_mode'(i_s_axis_tuser);
            r_s1_range <= in_range;
        end
        if (s1_go && r_s1_valid && emit) begin
            r_out_word  <= n_out_word;
            r_out_total <= (r_s1_mode == MODE_END) ? r_total : n_total;
            r_out_last  <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_total, r_out_word};
    assign o_m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free != '0) && (r_free <= LEN_W'(WORD_BITS)))
        else $error("free bit count out of range");

    a_empty_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == LEN_W'(WORD_BITS)) |-> (r_acc == '0))
        else $error("empty word holds stale bits");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

// ===== tb/sv/tb_variable_length_code_packer_unit.sv =====
module tb_variable_length_code_packer_unit;
    import vlcp_pkg::*;

    localparam int         SYMBOLS      = 256;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 8;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic [31:0]          total;
        logic                 last;
    } t_packed_word;

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;  // symbol, code_value, code_length, 2'b0
    logic [S_TUSER_W-1:0] i_s_axis_tuser  = '0;  // mode
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;        // packed_word, total_bits
    logic                 o_m_axis_tlast;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int err_count     = 0;

    // packer model state
    t_entry               code_book [SYMBOLS];
    logic [WORD_BITS-1:0] acc_word;
    int                   room_bits;
    logic [31:0]          msg_bits;
    logic                 words_sent;
    t_packed_word         pending_words [$];
    logic [SYM_W-1:0]     hot_syms [16];

    variable_length_code_packer_unit #(
        .SYMBOL_COUNT(SYMBOLS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_message();
        acc_word   = '0;
        room_bits  = WORD_BITS;
        msg_bits   = '0;
        words_sent = 1'b0;
    endfunction

    function automatic void push_word(logic [WORD_BITS-1:0] w, logic l);
        t_packed_word e;
        e.word  = w;
        e.total = msg_bits;
        e.last  = l;
        pending_words.push_back(e);
    endfunction

    function automatic void predict_beat(logic [1:0] mode, logic [SYM_W-1:0] sym,
                                         logic [WORD_BITS-1:0] code, logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]     eff_len;
        logic [WORD_BITS-1:0] eff_code;
        int                   spill;
        case (mode)
            MODE_LOAD: begin
                eff_len = (len > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS) : len;
                if (sym < SYMBOLS) begin
                    code_book[sym].len  = eff_len;
                    code_book[sym].code = (eff_len == LEN_W'(WORD_BITS)) ? code :
                                          code & ((32'd1 << eff_len) - 32'd1);
                end
            end
            MODE_ENC: begin
                eff_len  = '0;
                eff_code = '0;
                if (sym < SYMBOLS) begin
                    eff_len  = code_book[sym].len;
                    eff_code = code_book[sym].code;
                end
                msg_bits = msg_bits + 32'(eff_len);
                if (eff_len != 0) begin
                    if (int'(eff_len) <= room_bits) begin
                        room_bits = room_bits - int'(eff_len);
                        acc_word  = acc_word | (eff_code << room_bits);
                        if (room_bits == 0) begin
                            push_word(acc_word, 1'b0);
                            acc_word   = '0;
                            room_bits  = WORD_BITS;
                            words_sent = 1'b1;
                        end
                    end else begin
                        // split code: top bits close this word, rest opens the next
                        spill = int'(eff_len) - room_bits;
                        push_word(acc_word | (eff_code >> spill), 1'b0);
                        room_bits  = WORD_BITS - spill;
                        acc_word   = eff_code << room_bits;
                        words_sent = 1'b1;
                    end
                end
            end
            MODE_END: begin
                if (room_bits < WORD_BITS) begin
                    push_word(acc_word, 1'b1);
                end else if (!words_sent) begin
                    push_word('0, 1'b1);
                end
                clear_message();
            end
            default: ;
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic send_beat(input logic [1:0] mode, input logic [SYM_W-1:0] sym,
                             input logic [WORD_BITS-1:0] code, input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, len, code, sym};
        i_s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_beat(mode, sym, code, len);
    endtask

    // messages: optional table loads, a run of mostly encodes, then end of message in most rounds
    task automatic run_messages(input int n_items);
        int               done_items;
        int               n_enc;
        int               k;
        logic [SYM_W-1:0] s;
        logic [LEN_W-1:0] len;
        done_items = 0;
        foreach (hot_syms[i]) hot_syms[i] = SYM_W'($urandom);
        while (done_items < n_items) begin
            if ($urandom_range(1) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    s = ($urandom_range(4) == 0) ? SYM_W'($urandom)
                                                 : hot_syms[$urandom_range(15)];
                    case ($urandom_range(9))
                        0:       len = '0;
                        1:       len = LEN_W'($urandom_range(33, 63));
                        2:       len = LEN_W'(WORD_BITS);
                        3, 4, 5: len = LEN_W'($urandom_range(1, 8));
                        default: len = LEN_W'($urandom_range(1, 31));
                    endcase
                    send_beat(MODE_LOAD, s, $urandom, len);
                    done_items++;
                end
            end
            n_enc = $urandom_range(1, 30);
            repeat (n_enc) begin
                k = $urandom_range(19);
                if (k == 0) begin
                    send_beat(MODE_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
                end else if (k == 1) begin
                    send_beat(MODE_END, SYM_W'($urandom), $urandom, LEN_W'($urandom));
                end else if (k == 2) begin
                    send_beat(MODE_ENC, SYM_W'($urandom), $urandom, LEN_W'($urandom));
                end else begin
                    send_beat(MODE_ENC, hot_syms[$urandom_range(15)], $urandom,
                              LEN_W'($urandom));
                end
                done_items++;
            end
            if ($urandom_range(9) != 0) begin
                send_beat(MODE_END, SYM_W'($urandom), $urandom, LEN_W'($urandom));
                done_items++;
            end
        end
    endtask

    task automatic test_code_table_and_flush();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_beat(MODE_END, 8'd0, 32'd0, 6'd0);                  // empty message
        send_beat(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);     // ignored
        send_beat(MODE_ENC, 8'd200, 32'hFFFF_FFFF, 6'h3F);       // never loaded
        send_beat(MODE_END, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_beat(MODE_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);         // zero length
        send_beat(MODE_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
        send_beat(MODE_LOAD, 8'd1, 32'hDEAD_BEEF, 6'h3F);        // saturates to 32
        send_beat(MODE_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd5);         // masked code
        send_beat(MODE_LOAD, 8'd3, 32'd0, 6'd1);
        send_beat(MODE_LOAD, 8'd4, 32'h2AAA_AAAB, 6'd31);
        send_beat(MODE_ENC, 8'd255, 32'd0, 6'd0);                // fills one word
        send_beat(MODE_END, 8'd0, 32'd0, 6'd0);                  // word boundary
        send_beat(MODE_ENC, 8'd0, 32'hFFFF_FFFF, 6'h3F);
        send_beat(MODE_ENC, 8'd2, 32'd0, 6'd0);
        send_beat(MODE_ENC, 8'd4, 32'd0, 6'd0);                  // split
        send_beat(MODE_ENC, 8'd3, 32'd0, 6'd0);
        send_beat(MODE_ENC, 8'd1, 32'd0, 6'd0);                  // split, full width
        send_beat(MODE_END, 8'd0, 32'd0, 6'd0);                  // partial word
        send_beat(MODE_ENC, 8'd0, 32'd0, 6'd0);
        send_beat(MODE_END, 8'd0, 32'd0, 6'd0);
    endtask

    task automatic test_stream_no_idle();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_messages(250);
    endtask

    task automatic test_sender_gaps();
        src_idle_pct  = 61;
        snk_stall_pct = 0;
        run_messages(250);
    endtask

    task automatic test_receiver_stalls();
        src_idle_pct  = 0;
        snk_stall_pct = 61;
        run_messages(250);
    endtask

    task automatic test_both_idle();
        src_idle_pct  = 15;
        snk_stall_pct = 15;
        run_messages(200);
    endtask

    task automatic test_long_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 300;
        run_messages(150);
    endtask

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_packed_word exp_w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_words.size() == 0) begin
                report_error($sformatf("unexpected beat tdata=%h tlast=%b",
                                       o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                exp_w = pending_words.pop_front();
                if (o_m_axis_tdata[31:0] !== exp_w.word)
                    report_error($sformatf("packed_word %h, expected %h",
                                           o_m_axis_tdata[31:0], exp_w.word));
                if (o_m_axis_tdata[63:32] !== exp_w.total)
                    report_error($sformatf("total_bits %0d, expected %0d",
                                           o_m_axis_tdata[63:32], exp_w.total));
                if (o_m_axis_tlast !== exp_w.last)
                    report_error($sformatf("is_last %b, expected %b",
                                           o_m_axis_tlast, exp_w.last));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        foreach (code_book[i]) code_book[i] = '0;
        clear_message();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_code_table_and_flush();
        test_stream_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_long_backpressure();
        i_s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vlcp_pkg.sv
rtl/variable_length_code_packer_unit.sv
tb/sv/tb_variable_length_code_packer_unit.sv
